// File: rtl/bved_pkg.sv
// package for the beacon vendor element detector
// payload structs, element walk phases, register map and frame offsets; no dependencies
`timescale 1ns / 1ps

package bved_pkg;

  // input transfer: one captured byte and its end-of-capture mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic [47:0] station_address;
    logic [7:0]  name_length;
  } out_item_t;

  // element walker phases
  typedef enum logic [2:0] {
    PH_TYPE       = 3'd0,
    PH_LEN_VENDOR = 3'd1,
    PH_LEN_OTHER  = 3'd2,
    PH_ID         = 3'd3,
    PH_SKIP       = 3'd4
  } phase_t;

  // register indexes (byte address 4 * index)
  localparam logic [1:0] REG_HEADER_SKIP = 2'd0;
  localparam logic [1:0] REG_VENDOR_TAG  = 2'd1;
  localparam logic [1:0] REG_VENDOR_ID   = 2'd2;

  localparam logic [7:0]  HEADER_SKIP_RST = 8'd18;
  localparam logic [7:0]  VENDOR_TAG_RST  = 8'd221;
  localparam logic [31:0] VENDOR_ID_RST   = 32'h0050_f204;

  // frame layout
  localparam logic [7:0] FC_MASK       = 8'hfc;
  localparam logic [7:0] FC_BEACON     = 8'h80;
  localparam int         ADDR_FIRST    = 16;
  localparam int         ADDR_END      = 22;
  localparam int         SSID_LEN_OFS  = 37;
  localparam int         ELEMENTS_OFS  = 38;
  localparam int         VENDOR_MIN_LEN = 4;

endpackage

// File: rtl/beacon_vendor_element_detector.sv
// beacon vendor element detector, top level
// byte parser, configuration registers and result register; depends on bved_pkg
`timescale 1ns / 1ps

// Usage
//   in_*  : one byte of a captured frame per transfer, last_byte marks the final byte.
//   out_* : one result per matching beacon frame (station address and SSID length).
//   apb   : header_skip at 0x0, vendor_tag at 0x4, vendor_id at 0x8; pready is tied high,
//           reads return the stored value, other addresses are ignored.
// Throughput: one byte per clock cycle while in_stall is low, set by the single pass of
//   the byte parser; every byte updates the frame state at the edge at which it is taken.
// Match: a result sits in the output register in the cycle after the transfer of the
//   fourth matching identifier byte.
// Stall: the output register holds the result while out_stall is high; in_stall is
//   raised only while that register is full and stalled, so bytes keep flowing while
//   no result is waiting.
// Reset (synchronous, rst_n low): registers return to 18 / 221 / 0x0050f204, the frame
//   state clears and the output register empties.
// A final-byte mark clears the frame state after that byte has been parsed, so the
//   next byte starts a new capture.

module beacon_vendor_element_detector #(
  parameter int POSITION_LIMIT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  bved_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output bved_pkg::out_item_t out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import bved_pkg::*;

  // position counter width, and a compare width that also holds header_skip and
  // the 9-bit element start offset
  localparam int PW = $clog2(POSITION_LIMIT + 1);
  localparam int RW = (PW > 9) ? PW : 9;

  // configuration registers
  logic [7:0]  header_skip_r;
  logic [7:0]  vendor_tag_r;
  logic [31:0] vendor_id_r;

  // frame state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [47:0]   addr_r, addr_nxt;
  logic [7:0]    ssid_len_r, ssid_len_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    remain_r, remain_nxt;
  logic [1:0]    progress_r, progress_nxt;
  logic          frame_done_r, frame_done_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          in_xfer;
  logic          cfg_wr;
  logic          active;
  logic [RW-1:0] pos_ext;
  logic [RW-1:0] rel;
  logic [RW-1:0] elem_start;
  logic [7:0]    want;
  logic [7:0]    remain_dec;
  logic          hit;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= HEADER_SKIP_RST;
      vendor_tag_r  <= VENDOR_TAG_RST;
      vendor_id_r   <= VENDOR_ID_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HEADER_SKIP: header_skip_r <= pwdata[7:0];
        REG_VENDOR_TAG:  vendor_tag_r  <= pwdata[7:0];
        REG_VENDOR_ID:   vendor_id_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEADER_SKIP: prdata = {24'd0, header_skip_r};
      REG_VENDOR_TAG:  prdata = {24'd0, vendor_tag_r};
      REG_VENDOR_ID:   prdata = vendor_id_r;
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshakes: input waits only while a result is held back
  // ---------------------------------------------------------------------------
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // byte parser
  // ---------------------------------------------------------------------------
  assign pos_ext    = RW'(pos_r);
  assign rel        = pos_ext - RW'(header_skip_r);
  assign elem_start = RW'(ELEMENTS_OFS) + RW'(ssid_len_r);
  assign active     = ~frame_done_r && (pos_r < PW'(POSITION_LIMIT)) &&
                      (pos_ext >= RW'(header_skip_r));
  assign remain_dec = remain_r - 8'd1;

  // identifier byte expected next, first byte most significant
  always_comb begin
    case (progress_r)
      2'd0:    want = vendor_id_r[31:24];
      2'd1:    want = vendor_id_r[23:16];
      2'd2:    want = vendor_id_r[15:8];
      default: want = vendor_id_r[7:0];
    endcase
  end

  // next frame state
  always_comb begin
    pos_nxt        = pos_r;
    addr_nxt       = addr_r;
    ssid_len_nxt   = ssid_len_r;
    phase_nxt      = phase_r;
    remain_nxt     = remain_r;
    progress_nxt   = progress_r;
    frame_done_nxt = frame_done_r;
    hit            = 1'b0;

    if (in_xfer) begin
      if (active) begin
        if (rel == '0) begin
          // frame control byte: only beacons go further
          if ((in_data.data_byte & FC_MASK) != FC_BEACON) frame_done_nxt = 1'b1;
        end else if (rel >= RW'(ADDR_FIRST) && rel < RW'(ADDR_END)) begin
          addr_nxt = {addr_r[39:0], in_data.data_byte};
        end else if (rel == RW'(SSID_LEN_OFS)) begin
          ssid_len_nxt = in_data.data_byte;
        end else if (rel >= elem_start) begin
          // element walk
          case (phase_r)
            PH_TYPE: begin
              phase_nxt = (in_data.data_byte == vendor_tag_r) ? PH_LEN_VENDOR : PH_LEN_OTHER;
            end
            PH_LEN_VENDOR: begin
              remain_nxt   = in_data.data_byte;
              progress_nxt = 2'd0;
              if (in_data.data_byte >= 8'(VENDOR_MIN_LEN)) phase_nxt = PH_ID;
              else if (in_data.data_byte == 8'd0)          phase_nxt = PH_TYPE;
              else                                         phase_nxt = PH_SKIP;
            end
            PH_LEN_OTHER: begin
              remain_nxt = in_data.data_byte;
              phase_nxt  = (in_data.data_byte == 8'd0) ? PH_TYPE : PH_SKIP;
            end
            PH_ID: begin
              remain_nxt = remain_dec;
              if (in_data.data_byte != want) begin
                phase_nxt = (remain_dec == 8'd0) ? PH_TYPE : PH_SKIP;
              end else begin
                progress_nxt = progress_r + 2'd1;
                if (progress_r == 2'd3) begin
                  phase_nxt      = (remain_dec == 8'd0) ? PH_TYPE : PH_SKIP;
                  hit            = 1'b1;
                  frame_done_nxt = 1'b1;
                end
              end
            end
            PH_SKIP: begin
              remain_nxt = remain_dec;
              if (remain_dec == 8'd0) phase_nxt = PH_TYPE;
            end
            default: begin
              phase_nxt = PH_TYPE;
            end
          endcase
        end
      end

      // position saturates at the limit
      if (pos_r < PW'(POSITION_LIMIT)) pos_nxt = pos_r + PW'(1);

      // end of capture: start afresh
      if (in_data.last_byte) begin
        pos_nxt        = '0;
        addr_nxt       = '0;
        ssid_len_nxt   = '0;
        phase_nxt      = PH_TYPE;
        remain_nxt     = '0;
        progress_nxt   = '0;
        frame_done_nxt = 1'b0;
      end
    end
  end

  // result register: loads on a match, empties when the transfer completes
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (hit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.station_address = addr_r;
      out_data_nxt.name_length     = ssid_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      addr_r       <= '0;
      ssid_len_r   <= '0;
      phase_r      <= PH_TYPE;
      remain_r     <= '0;
      progress_r   <= '0;
      frame_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      addr_r       <= addr_nxt;
      ssid_len_r   <= ssid_len_nxt;
      phase_r      <= phase_nxt;
      remain_r     <= remain_nxt;
      progress_r   <= progress_nxt;
      frame_done_r <= frame_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // input held back only by a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled without a pending result");

  // a new result only follows an accepted byte
  a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transfer");

  // the final byte restarts the capture
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_byte) |=> (pos_r == '0 && !frame_done_r))
    else $error("frame state not cleared after final byte");

  // a frame cannot be finished before its first byte
  a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> !frame_done_r)
    else $error("frame marked done at capture start");

endmodule

// File: sim/beacon_vendor_element_detector_tb.sv
// self-checking testbench for the beacon vendor element detector
// streams captured frames through the byte channel, predicts sightings and checks them in order
// depends on bved_pkg and beacon_vendor_element_detector from rtl
`timescale 1ns / 1ps

module beacon_vendor_element_detector_tb;
  import bved_pkg::*;

  localparam int         POS_LIMIT     = 4096;
  localparam int         QUIET_LIMIT   = 1000;
  localparam int         IDLE_PCT      = 13;
  localparam logic [1:0] REG_UNUSED    = 2'd3;    // no register behind this index
  localparam logic [7:0] PLAIN_ELEMENT = 8'h01;   // filler element type for long captures

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  beacon_vendor_element_detector #(
    .POSITION_LIMIT(POS_LIMIT)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // bytes waiting to be offered, sightings waiting to come out
  in_item_t  pending[$];
  out_item_t expected_sightings[$];
  logic [7:0] capture[$];

  // idling knobs, changed per phase by the stimulus block
  int idle_pct = IDLE_PCT;
  int stall_pct = IDLE_PCT;

  int errors = 0;
  int bytes_queued = 0;
  int captures_sent = 0;
  int registers_written = 0;
  int sightings_predicted = 0;
  int sightings_checked = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // frame parser prediction: own copy of the registers and the frame state
  // ---------------------------------------------------------------------------
  logic [7:0]  header_skip_now = HEADER_SKIP_RST;
  logic [7:0]  vendor_tag_now  = VENDOR_TAG_RST;
  logic [31:0] vendor_id_now   = VENDOR_ID_RST;

  int          frame_pos = 0;
  logic [47:0] addr_acc = '0;
  logic [7:0]  ssid_len_seen = '0;
  phase_t      walk_phase = PH_TYPE;
  logic [7:0]  elem_left = '0;
  logic [2:0]  id_matched = '0;
  bit          frame_closed = 1'b0;

  // walk one element byte; returns 1 when the full identifier has matched
  function automatic bit walk_element_byte(input logic [7:0] b);
    int         sh;
    logic [7:0] want;
    walk_element_byte = 1'b0;
    case (walk_phase)
      PH_TYPE: begin
        walk_phase = (b == vendor_tag_now) ? PH_LEN_VENDOR : PH_LEN_OTHER;
      end
      PH_LEN_VENDOR: begin
        elem_left = b;
        id_matched = '0;
        if (b >= VENDOR_MIN_LEN) walk_phase = PH_ID;
        else walk_phase = (b == 8'd0) ? PH_TYPE : PH_SKIP;
      end
      PH_LEN_OTHER: begin
        elem_left = b;
        walk_phase = (b == 8'd0) ? PH_TYPE : PH_SKIP;
      end
      PH_ID: begin
        // identifier bytes compare most significant first
        sh = 8 * (3 - int'(id_matched[1:0]));
        want = 8'(vendor_id_now >> sh);
        elem_left = elem_left - 8'd1;
        if (b != want) begin
          walk_phase = (elem_left == 8'd0) ? PH_TYPE : PH_SKIP;
        end else begin
          id_matched = id_matched + 3'd1;
          if (id_matched >= 3'd4) begin
            walk_phase = (elem_left == 8'd0) ? PH_TYPE : PH_SKIP;
            walk_element_byte = 1'b1;
          end
        end
      end
      default: begin
        elem_left = elem_left - 8'd1;
        if (elem_left == 8'd0) walk_phase = PH_TYPE;
      end
    endcase
  endfunction

  // advance the frame state by one accepted byte, queueing any sighting it causes
  function automatic void parse_capture_byte(input in_item_t it);
    int        rel;
    out_item_t hit;
    if (!frame_closed && frame_pos < POS_LIMIT && frame_pos >= int'(header_skip_now)) begin
      rel = frame_pos - int'(header_skip_now);
      if (rel == 0) begin
        // frame control byte decides beacon or not
        if ((it.data_byte & FC_MASK) != FC_BEACON) frame_closed = 1'b1;
      end else if (rel >= ADDR_FIRST && rel < ADDR_END) begin
        addr_acc = {addr_acc[39:0], it.data_byte};
      end else if (rel == SSID_LEN_OFS) begin
        ssid_len_seen = it.data_byte;
      end else if (rel >= ELEMENTS_OFS + int'(ssid_len_seen)) begin
        if (walk_element_byte(it.data_byte)) begin
          hit.station_address = addr_acc;
          hit.name_length = ssid_len_seen;
          expected_sightings.push_back(hit);
          sightings_predicted++;
          frame_closed = 1'b1;
        end
      end
    end
    // position saturates, so anything past the limit is ignored until the end mark
    if (frame_pos < POS_LIMIT) frame_pos++;
    if (it.last_byte) begin
      frame_pos = 0;
      addr_acc = '0;
      ssid_len_seen = '0;
      walk_phase = PH_TYPE;
      elem_left = '0;
      id_matched = '0;
      frame_closed = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: offers queued bytes, predicts each one at its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    bit taken;
    bit offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) parse_capture_byte(in_data);
      // a stalled byte stays on the bus unchanged
      if (!(in_valid && !taken)) begin
        offer = (pending.size() > 0) && ($urandom_range(0, 99) >= idle_pct);
        if (offer) begin
          in_data <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sighting monitor: checks each result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sighting_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sightings.size() == 0) begin
        report_mismatch("sighting with nothing expected", 64'(out_data.station_address), '0);
      end else begin
        want = expected_sightings.pop_front();
        if (out_data.station_address !== want.station_address)
          report_mismatch("station_address", 64'(out_data.station_address),
                          64'(want.station_address));
        if (out_data.name_length !== want.name_length)
          report_mismatch("name_length", 64'(out_data.name_length), 64'(want.name_length));
      end
      sightings_checked++;
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: too long without any transfer on either channel or the register port
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register port and capture building
  // ---------------------------------------------------------------------------

  // setup cycle then access cycle; the register takes the value at the access edge
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_HEADER_SKIP: header_skip_now = value[7:0];
      REG_VENDOR_TAG:  vendor_tag_now = value[7:0];
      REG_VENDOR_ID:   vendor_id_now = value;
      default: ;  // unmapped index, nothing changes
    endcase
    registers_written++;
  endtask

  task automatic write_all(input logic [7:0] skip, input logic [7:0] tag,
                           input logic [31:0] id);
    write_register(REG_HEADER_SKIP, 32'(skip));
    write_register(REG_VENDOR_TAG, 32'(tag));
    write_register(REG_VENDOR_ID, id);
  endtask

  // sender holds off until all bytes are through and every sighting is back
  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || expected_sightings.size() != 0) @(posedge clk);
    // bytes that cause no sighting may still be in flight
    repeat (4) @(posedge clk);
  endtask

  // capture header, frame control, address at 16, SSID length at 37, SSID body
  task automatic start_beacon(input logic [7:0] fc, input logic [47:0] addr,
                              input logic [7:0] ssid_len);
    capture.delete();
    repeat (header_skip_now) capture.push_back(8'($urandom));
    capture.push_back(fc);
    repeat (15) capture.push_back(8'($urandom));
    for (int i = 5; i >= 0; i--) capture.push_back(addr[8*i +: 8]);
    repeat (15) capture.push_back(8'($urandom));
    capture.push_back(ssid_len);
    repeat (ssid_len) capture.push_back(8'($urandom));
  endtask

  task automatic add_element(input logic [7:0] kind, input logic [7:0] len);
    capture.push_back(kind);
    capture.push_back(len);
    repeat (len) capture.push_back(8'($urandom));
  endtask

  // vendor element opening with the given identifier; len is at least four
  task automatic add_vendor(input logic [7:0] len, input logic [31:0] id);
    capture.push_back(vendor_tag_now);
    capture.push_back(len);
    for (int i = 3; i >= 0; i--) capture.push_back(id[8*i +: 8]);
    repeat (int'(len) - 4) capture.push_back(8'($urandom));
  endtask

  task automatic send_capture();
    in_item_t it;
    foreach (capture[i]) begin
      it.data_byte = capture[i];
      it.last_byte = (i == capture.size() - 1);
      pending.push_back(it);
    end
    bytes_queued += capture.size();
    captures_sent++;
  endtask

  function automatic logic [7:0] not_beacon_fc();
    logic [7:0] fc;
    do fc = 8'($urandom); while ((fc & FC_MASK) == FC_BEACON);
    return fc;
  endfunction

  // mostly well formed beacons with a mix of elements, some broken or foreign frames
  task automatic random_capture();
    int         kind;
    int         cut;
    logic [7:0] fc;
    logic [7:0] ssid;
    logic [31:0] near_id;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // plain noise of any short length
      capture.delete();
      repeat ($urandom_range(1, 60)) capture.push_back(8'($urandom));
    end else begin
      fc = (kind < 25) ? not_beacon_fc() : (FC_BEACON | 8'($urandom_range(0, 3)));
      ssid = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 32));
      start_beacon(fc, {16'($urandom), 32'($urandom)}, ssid);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0, 1: add_element(8'($urandom), 8'($urandom_range(0, 24)));
          2: add_element(vendor_tag_now, 8'($urandom_range(0, 3)));
          3: begin
            // near miss: one identifier byte differs
            near_id = vendor_id_now ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
            add_vendor(8'($urandom_range(4, 20)), near_id);
          end
          default: add_vendor(8'($urandom_range(4, 24)), vendor_id_now);
        endcase
      end
      // sometimes the capture stops short, anywhere
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, capture.size());
        while (capture.size() > cut) void'(capture.pop_back());
      end
    end
    send_capture();
  endtask

  task automatic random_phase(input int min_sightings, input int min_bytes,
                              input bit pause_often);
    int first_pred;
    int first_bytes;
    int frames;
    first_pred = sightings_predicted;
    first_bytes = bytes_queued;
    frames = 0;
    while ((sightings_predicted - first_pred < min_sightings ||
            bytes_queued - first_bytes < min_bytes) && frames < 400) begin
      while (pending.size() > 256) @(posedge clk);
      random_capture();
      frames++;
      if (pause_often && frames % 6 == 0) wait_drained();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: directed captures at reset settings, then extreme and random settings
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // exact four byte vendor element, match on the final byte of the capture
    start_beacon(FC_BEACON, 48'hffff_ffff_ffff, 8'd4);
    add_element(PLAIN_ELEMENT, 8'd3);
    add_vendor(8'd4, vendor_id_now);
    send_capture();

    // empty and too short vendor elements, a wrong id, then two matches (second ignored)
    start_beacon(FC_BEACON | 8'h03, 48'h0, 8'd0);
    add_element(vendor_tag_now, 8'd0);
    add_element(vendor_tag_now, 8'd3);
    add_vendor(8'd6, vendor_id_now ^ 32'hff00_0000);
    add_element(PLAIN_ELEMENT, 8'd0);
    add_vendor(8'd9, vendor_id_now);
    add_vendor(8'd4, vendor_id_now);
    add_element(PLAIN_ELEMENT, 8'd2);
    send_capture();

    // not a beacon: matches inside are ignored
    start_beacon(8'h84, 48'h1234_5678_9abc, 8'd2);
    add_vendor(8'd4, vendor_id_now);
    send_capture();
    start_beacon(8'h00, 48'h1234_5678_9abc, 8'd2);
    add_vendor(8'd4, vendor_id_now);
    send_capture();

    // capture ends after the third identifier byte
    start_beacon(FC_BEACON, 48'ha5a5_5a5a_0f0f, 8'd1);
    add_vendor(8'd8, vendor_id_now);
    repeat (5) void'(capture.pop_back());
    send_capture();

    // captures that end inside the capture header, down to a single byte
    capture.delete();
    repeat (5) capture.push_back(8'($urandom));
    send_capture();
    capture.delete();
    capture.push_back(8'hff);
    send_capture();

    // longest SSID, element running past the end after the match
    start_beacon(FC_BEACON | 8'h01, 48'h8000_0000_0001, 8'd255);
    add_vendor(8'd40, vendor_id_now);
    repeat (20) void'(capture.pop_back());
    send_capture();

    // long capture: match early, then past the position limit
    start_beacon(FC_BEACON, 48'h0102_0304_0506, 8'd0);
    add_vendor(8'd4, vendor_id_now);
    repeat (16) add_element(PLAIN_ELEMENT, 8'd255);
    send_capture();
    // long capture: match only beyond the position limit, so none
    start_beacon(FC_BEACON, 48'h0a0b_0c0d_0e0f, 8'd0);
    repeat (16) add_element(PLAIN_ELEMENT, 8'd255);
    add_vendor(8'd4, vendor_id_now);
    send_capture();
    wait_drained();

    // lower extremes of header skip and vendor tag, all ones identifier
    write_all(8'd0, 8'd0, 32'hffff_ffff);
    start_beacon(FC_BEACON, 48'hffff_0000_ffff, 8'd0);
    add_vendor(8'd4, vendor_id_now);
    send_capture();
    random_phase(4, 300, 1'b0);

    // upper extremes of header skip and vendor tag: long capture header, all zero identifier
    write_all(8'd255, 8'd255, 32'h0000_0000);
    random_phase(3, 600, 1'b0);

    // write to an unmapped index must leave the settings alone
    write_register(REG_UNUSED, $urandom);
    random_phase(3, 200, 1'b0);

    // main random part over several settings
    for (int setting = 0; setting < 4; setting++) begin
      if (setting == 0) write_all(HEADER_SKIP_RST, VENDOR_TAG_RST, VENDOR_ID_RST);
      else write_all(8'($urandom_range(0, 40)), 8'($urandom), $urandom);
      // one stretch with no idling on either side
      idle_pct = (setting == 1) ? 0 : IDLE_PCT;
      stall_pct = (setting == 1) ? 0 : IDLE_PCT;
      // one setting where the sender keeps waiting for every sighting to return
      random_phase(10, 200, setting == 2);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("summary: %0d captures, %0d bytes, %0d register writes, %0d sightings checked",
             captures_sent, bytes_queued, registers_written, sightings_checked);
    if (errors == 0 && expected_sightings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bved_pkg.sv
rtl/beacon_vendor_element_detector.sv
sim/beacon_vendor_element_detector_tb.sv
